// ----- sv/kswe_pkg.sv -----
`timescale 1ns / 1ps

package kswe_pkg;

    localparam int MAX_LEN    = 4096;
    localparam int KMER_LEN   = 8;
    localparam int KMER_SPACE = 65536;

    localparam int POS_W  = $clog2(MAX_LEN);
    localparam int LEN_W  = POS_W + 1;
    localparam int KIDX_W = $clog2(KMER_SPACE);
    localparam int RUN_W  = $clog2(KMER_LEN + 1);
    localparam int WIN_W  = 7;
    localparam int SW     = LEN_W + 2;

    localparam logic [WIN_W-1:0] WIDTH_RESET = 7'd16;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    typedef struct packed {
        logic       kind;
        logic [7:0] seq_byte;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [6:0]  best_matches;
        logic [11:0] donor_pos;
        logic [11:0] acceptor_pos;
        logic        found;
    } t_result;

    typedef struct packed {
        logic clr;
        logic step;
    } t_kmer_ctl;

    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } t_base;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_CNT_RD,
        S_CNT_K,
        S_CNT_W,
        S_PFX_RD,
        S_PFX_W,
        S_FIL_RD,
        S_FIL_K,
        S_FIL_W,
        S_SCN_RD,
        S_SCN_K,
        S_SCN_B,
        S_HIT_RD,
        S_HIT_P,
        S_WIN_A,
        S_WIN_B,
        S_W1_RD,
        S_W1_C,
        S_W2_RD,
        S_W2_C1,
        S_W2_C2,
        S_W_END,
        S_DONE
    } t_state;

    function automatic t_base base_code(input logic [7:0] b);
        t_base r;
        r.valid = 1'b1;
        case (b)
            CHAR_A:  r.code = 2'd0;
            CHAR_C:  r.code = 2'd1;
            CHAR_G:  r.code = 2'd2;
            CHAR_T:  r.code = 2'd3;
            default: begin
                r.code  = 2'd0;
                r.valid = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- sv/kswe_ram.sv -----
`timescale 1ns / 1ps

module kswe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one word, register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/kswe_kmer.sv -----
`timescale 1ns / 1ps

module kswe_kmer
    import kswe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_kmer_ctl         i_ctl,
    input  logic [7:0]        i_byte,
    output logic              o_fire,
    output logic [KIDX_W-1:0] o_idx
);

    logic [RUN_W-1:0]  r_run;
    logic [KIDX_W-1:0] r_oligo;
    logic [RUN_W-1:0]  n_run;
    logic [KIDX_W-1:0] n_oligo;
    t_base             base;

    // restart on a non-ACGT byte, hold the run below a full k-mer
    always_comb begin
        base    = base_code(i_byte);
        o_fire  = base.valid && (r_run == RUN_W'(KMER_LEN - 1));
        n_oligo = base.valid ? {r_oligo[KIDX_W-3:0], base.code} : '0;
        o_idx   = n_oligo;
        if (!base.valid) begin
            n_run = '0;
        end else if (o_fire) begin
            n_run = r_run;
        end else begin
            n_run = r_run + RUN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_run   <= '0;
            r_oligo <= '0;
        end else if (i_ctl.step) begin
            r_run   <= n_run;
            r_oligo <= n_oligo;
        end
    end

endmodule

// ----- sv/kmer_seed_window_extend.sv -----
`timescale 1ns / 1ps

// Seed-and-extend similarity of a donor and an acceptor byte sequence.
// Bytes load at one beat per cycle while busy is low. The acceptor beat
// with last set starts the comparison: busy stays high through the single
// result beat, which is shown on o_result for one cycle with o_valid and
// cannot be held off. The comparison is run by one sequencer over simple
// dual-port memories: it counts k-mers of the longer sequence, sweeps all
// 65536 buckets to turn the counts into offsets, places hits, scans the
// k-mers of the other sequence, and for each index hit compares a window of
// byte pairs one pair at a time. After each result, and after reset, a
// clearing pass over all 65536 entries empties the k-mer count memory
// before busy falls.
module kmer_seed_window_extend
    import kswe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    output logic             o_valid,
    output t_result          o_result,
    input  logic             i_cfg_we,
    input  logic [WIN_W-1:0] i_cfg_wdata
);

    t_state r_state, n_state;

    logic [LEN_W-1:0]  r_dlen, n_dlen, r_alen, n_alen;
    logic [WIN_W-1:0]  r_width;
    logic              r_dx, n_dx;
    logic [LEN_W-1:0]  r_i, n_i;
    logic [KIDX_W:0]   r_cidx, n_cidx;
    logic [LEN_W-1:0]  r_sum, n_sum;
    logic [KIDX_W-1:0] r_kidx, n_kidx;
    logic [POS_W-1:0]  r_q, n_q;
    logic [LEN_W-1:0]  r_h, n_h, r_hend, n_hend;
    logic signed [SW-1:0] r_pi, n_pi, r_pj, n_pj;
    logic signed [SW-1:0] r_si, n_si, r_sj, n_sj;
    logic signed [SW-1:0] r_ei, n_ei, r_ej, n_ej;
    logic signed [SW-1:0] r_wi, n_wi, r_wj, n_wj;
    logic signed [SW-1:0] r_off, n_off;
    logic [WIN_W-1:0]  r_k, n_k;
    logic [WIN_W:0]    r_n, n_n;
    logic [WIN_W-1:0]  r_wbest, n_wbest;
    logic [WIN_W-1:0]  r_gbest, n_gbest;
    logic [POS_W-1:0]  r_bi, n_bi, r_bj, n_bj;
    logic              r_eq1, n_eq1;
    logic              r_valid, n_valid;
    t_result           r_res, n_res;

    // memory ports
    logic             d_we, a_we, c_we, s_we, h_we;
    logic [POS_W-1:0] d_waddr, a_waddr, d_raddr, a_raddr, h_waddr, h_raddr;
    logic [7:0]       d_rdata, a_rdata;
    logic [KIDX_W-1:0] c_waddr, c_raddr, s_waddr, s_raddr;
    logic [LEN_W-1:0] c_wdata, c_rdata, s_wdata, s_rdata;
    logic [POS_W-1:0] h_rdata;

    t_kmer_ctl         kctl;
    logic [7:0]        kbyte;
    logic              kfire;
    logic [KIDX_W-1:0] kidx;

    logic                 accept;
    logic [LEN_W-1:0]     alen_new;
    logic [LEN_W-1:0]     xlen, olen;
    logic [7:0]           x_byte, o_byte;
    logic signed [SW-1:0] w_s, xl_s, yl_s, p_s, q_s;
    logic signed [SW-1:0] wi_back, wj_back;
    logic [WIN_W:0]       n_upd;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    kswe_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_donor (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(i_item.seq_byte),
        .i_raddr(d_raddr), .o_rdata(d_rdata)
    );

    kswe_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_acceptor (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(i_item.seq_byte),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    kswe_ram #(.WIDTH(LEN_W), .DEPTH(KMER_SPACE)) u_count (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    kswe_ram #(.WIDTH(LEN_W), .DEPTH(KMER_SPACE)) u_fill (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    kswe_ram #(.WIDTH(POS_W), .DEPTH(MAX_LEN)) u_hits (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(r_q),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    kswe_kmer u_kmer (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(kctl), .i_byte(kbyte),
        .o_fire(kfire), .o_idx(kidx)
    );

    // shared operands
    always_comb begin
        alen_new = (r_alen < LEN_W'(MAX_LEN)) ? r_alen + LEN_W'(1) : r_alen;
        xlen     = r_dx ? r_dlen : r_alen;
        olen     = r_dx ? r_alen : r_dlen;
        x_byte   = r_dx ? d_rdata : a_rdata;
        o_byte   = r_dx ? a_rdata : d_rdata;
        w_s      = SW'(r_width);
        xl_s     = SW'(r_dlen);
        yl_s     = SW'(r_alen);
        p_s      = SW'(h_rdata);
        q_s      = SW'(r_q);
        wi_back  = r_wi - w_s;
        wj_back  = r_wj - w_s;
        n_upd    = r_n + (WIN_W+1)'(r_eq1) - (WIN_W+1)'(d_rdata == a_rdata);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_dlen  = r_dlen;   n_alen  = r_alen;   n_dx    = r_dx;
        n_i     = r_i;      n_cidx  = r_cidx;   n_sum   = r_sum;
        n_kidx  = r_kidx;   n_q     = r_q;      n_h     = r_h;
        n_hend  = r_hend;   n_pi    = r_pi;     n_pj    = r_pj;
        n_si    = r_si;     n_sj    = r_sj;     n_ei    = r_ei;
        n_ej    = r_ej;     n_wi    = r_wi;     n_wj    = r_wj;
        n_off   = r_off;    n_k     = r_k;      n_n     = r_n;
        n_wbest = r_wbest;  n_gbest = r_gbest;  n_bi    = r_bi;
        n_bj    = r_bj;     n_eq1   = r_eq1;    n_res   = r_res;
        n_valid = 1'b0;

        d_we = 1'b0;  d_waddr = r_dlen[POS_W-1:0];  d_raddr = r_wi[POS_W-1:0];
        a_we = 1'b0;  a_waddr = r_alen[POS_W-1:0];  a_raddr = r_wj[POS_W-1:0];
        c_we = 1'b0;  c_waddr = r_kidx;  c_wdata = c_rdata + LEN_W'(1);  c_raddr = kidx;
        s_we = 1'b0;  s_waddr = r_kidx;  s_wdata = s_rdata + LEN_W'(1);  s_raddr = kidx;
        h_we = 1'b0;  h_waddr = s_rdata[POS_W-1:0];  h_raddr = r_h[POS_W-1:0];
        kctl  = '0;
        kbyte = x_byte;

        unique case (r_state)
            // zero every k-mer count
            S_CLR: begin
                c_we    = 1'b1;
                c_waddr = r_cidx[KIDX_W-1:0];
                c_wdata = '0;
                n_cidx  = r_cidx + (KIDX_W+1)'(1);
                if (r_cidx[KIDX_W-1:0] == '1) begin
                    n_state = S_IDLE;
                end
            end
            // store beats, start comparing on the final acceptor beat
            S_IDLE: begin
                if (accept) begin
                    if (!i_item.kind) begin
                        d_we = (r_dlen < LEN_W'(MAX_LEN));
                        n_dlen = d_we ? r_dlen + LEN_W'(1) : r_dlen;
                    end else begin
                        a_we   = (r_alen < LEN_W'(MAX_LEN));
                        n_alen = alen_new;
                        if (i_item.last) begin
                            n_dx    = r_dlen > alen_new;
                            n_i     = '0;
                            n_gbest = '0;
                            n_bi    = '0;
                            n_bj    = '0;
                            kctl.clr = 1'b1;
                            n_state = S_CNT_RD;
                        end
                    end
                end
            end
            // count k-mers of the indexed sequence
            S_CNT_RD: begin
                d_raddr = r_i[POS_W-1:0];
                a_raddr = r_i[POS_W-1:0];
                if (r_i >= xlen) begin
                    kctl.clr = 1'b1;
                    n_cidx   = '0;
                    n_sum    = '0;
                    n_state  = S_PFX_RD;
                end else begin
                    n_state = S_CNT_K;
                end
            end
            S_CNT_K: begin
                kctl.step = 1'b1;
                n_kidx    = kidx;
                n_i       = r_i + LEN_W'(1);
                n_state   = kfire ? S_CNT_W : S_CNT_RD;
            end
            S_CNT_W: begin
                c_we    = 1'b1;
                n_state = S_CNT_RD;
            end
            // turn counts into bucket offsets
            S_PFX_RD: begin
                c_raddr = r_cidx[KIDX_W-1:0];
                if (r_cidx[KIDX_W]) begin
                    n_i     = '0;
                    n_state = S_FIL_RD;
                end else begin
                    n_state = S_PFX_W;
                end
            end
            S_PFX_W: begin
                s_we    = 1'b1;
                s_waddr = r_cidx[KIDX_W-1:0];
                s_wdata = r_sum;
                n_sum   = r_sum + c_rdata;
                n_cidx  = r_cidx + (KIDX_W+1)'(1);
                n_state = S_PFX_RD;
            end
            // place hit positions into their buckets
            S_FIL_RD: begin
                d_raddr = r_i[POS_W-1:0];
                a_raddr = r_i[POS_W-1:0];
                if (r_i >= xlen) begin
                    kctl.clr = 1'b1;
                    n_i      = '0;
                    n_state  = S_SCN_RD;
                end else begin
                    n_state = S_FIL_K;
                end
            end
            S_FIL_K: begin
                kctl.step = 1'b1;
                n_kidx    = kidx;
                n_q       = POS_W'(r_i - LEN_W'(KMER_LEN - 1));
                n_i       = r_i + LEN_W'(1);
                n_state   = kfire ? S_FIL_W : S_FIL_RD;
            end
            S_FIL_W: begin
                h_we    = 1'b1;
                s_we    = 1'b1;
                n_state = S_FIL_RD;
            end
            // scan k-mers of the other sequence
            S_SCN_RD: begin
                d_raddr = r_i[POS_W-1:0];
                a_raddr = r_i[POS_W-1:0];
                n_state = (r_i >= olen) ? S_DONE : S_SCN_K;
            end
            S_SCN_K: begin
                kbyte     = o_byte;
                kctl.step = 1'b1;
                n_q       = POS_W'(r_i - LEN_W'(KMER_LEN - 1));
                if (kfire) begin
                    n_state = S_SCN_B;
                end else begin
                    n_i     = r_i + LEN_W'(1);
                    n_state = S_SCN_RD;
                end
            end
            S_SCN_B: begin
                n_h     = s_rdata - c_rdata;
                n_hend  = s_rdata;
                n_state = S_HIT_RD;
            end
            // walk the bucket
            S_HIT_RD: begin
                if (r_h >= r_hend) begin
                    n_i     = r_i + LEN_W'(1);
                    n_state = S_SCN_RD;
                end else begin
                    n_state = S_HIT_P;
                end
            end
            S_HIT_P: begin
                n_pi    = r_dx ? p_s : q_s;
                n_pj    = r_dx ? q_s : p_s;
                n_state = S_WIN_A;
            end
            // clip the window start
            S_WIN_A: begin
                if ((r_pi < r_pj ? r_pi : r_pj) - w_s < 0) begin
                    n_si = (r_pi < r_pj) ? SW'(0) : r_pi - r_pj;
                    n_sj = (r_pi < r_pj) ? r_pj - r_pi : SW'(0);
                end else begin
                    n_si = r_pi - w_s;
                    n_sj = r_pj - w_s;
                end
                n_state = S_WIN_B;
            end
            // clip the window end
            S_WIN_B: begin
                if (xl_s - r_pi < yl_s - r_pj) begin
                    if (r_pi + SW'(KMER_LEN) + w_s >= xl_s) begin
                        n_ei = xl_s;
                        n_ej = r_pj - r_pi + xl_s;
                    end else begin
                        n_ei = r_pi + SW'(KMER_LEN) + w_s;
                        n_ej = r_pj + SW'(KMER_LEN) + w_s;
                    end
                end else begin
                    if (r_pj + SW'(KMER_LEN) + w_s >= yl_s) begin
                        n_ei = r_pi - r_pj + yl_s;
                        n_ej = yl_s;
                    end else begin
                        n_ei = r_pi + SW'(KMER_LEN) + w_s;
                        n_ej = r_pj + SW'(KMER_LEN) + w_s;
                    end
                end
                n_wi    = r_si;
                n_wj    = r_sj;
                n_k     = '0;
                n_n     = '0;
                n_state = S_W1_RD;
            end
            // fill the first window
            S_W1_RD: begin
                if (r_k < r_width && r_wi < r_ei && r_wj < r_ej) begin
                    n_state = S_W1_C;
                end else if (r_k < r_width) begin
                    n_h     = r_h + LEN_W'(1);
                    n_state = S_HIT_RD;
                end else begin
                    n_wbest = r_n[WIN_W-1:0];
                    n_off   = r_si - r_pi;
                    n_state = S_W2_RD;
                end
            end
            S_W1_C: begin
                n_n     = r_n + (WIN_W+1)'(d_rdata == a_rdata);
                n_k     = r_k + WIN_W'(1);
                n_wi    = r_wi + SW'(1);
                n_wj    = r_wj + SW'(1);
                n_state = S_W1_RD;
            end
            // slide the window
            S_W2_RD: begin
                n_state = (r_wi < r_ei && r_wj < r_ej) ? S_W2_C1 : S_W_END;
            end
            S_W2_C1: begin
                d_raddr = wi_back[POS_W-1:0];
                a_raddr = wj_back[POS_W-1:0];
                n_eq1   = (d_rdata == a_rdata);
                n_state = S_W2_C2;
            end
            S_W2_C2: begin
                n_n = n_upd;
                if (n_upd > (WIN_W+1)'(r_wbest)) begin
                    n_wbest = n_upd[WIN_W-1:0];
                    n_off   = wi_back + SW'(1) - r_pi;
                end
                n_wi    = r_wi + SW'(1);
                n_wj    = r_wj + SW'(1);
                n_state = S_W2_RD;
            end
            // keep the first strictly best window
            S_W_END: begin
                if (r_wbest > r_gbest) begin
                    n_gbest = r_wbest;
                    n_bi    = POS_W'(r_pi + r_off);
                    n_bj    = POS_W'(r_pj + r_off);
                end
                n_h     = r_h + LEN_W'(1);
                n_state = S_HIT_RD;
            end
            // emit the result beat and drop both sequences
            S_DONE: begin
                n_valid            = 1'b1;
                n_res.best_matches = r_gbest;
                n_res.found        = (r_gbest != '0);
                n_res.donor_pos    = r_bi;
                n_res.acceptor_pos = r_bj;
                n_dlen             = '0;
                n_alen             = '0;
                n_cidx             = '0;
                n_state            = S_CLR;
            end
            default: n_state = S_CLR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cidx  <= '0;
            r_dlen  <= '0;
            r_alen  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cidx  <= n_cidx;
            r_dlen  <= n_dlen;
            r_alen  <= n_alen;
            r_valid <= n_valid;
        end
    end

    // window width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dx    <= n_dx;    r_i     <= n_i;     r_sum   <= n_sum;
        r_kidx  <= n_kidx;  r_q     <= n_q;     r_h     <= n_h;
        r_hend  <= n_hend;  r_pi    <= n_pi;    r_pj    <= n_pj;
        r_si    <= n_si;    r_sj    <= n_sj;    r_ei    <= n_ei;
        r_ej    <= n_ej;    r_wi    <= n_wi;    r_wj    <= n_wj;
        r_off   <= n_off;   r_k     <= n_k;     r_n     <= n_n;
        r_wbest <= n_wbest; r_gbest <= n_gbest; r_bi    <= n_bi;
        r_bj    <= n_bj;    r_eq1   <= n_eq1;   r_res   <= n_res;
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef NO_ASSERTIONS
    a_valid_then_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_CLR && busy))
        else $error("result beat outside the clearing pass");

    a_found_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.found == (o_result.best_matches != '0)))
        else $error("found disagrees with best_matches");

    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W2_RD) |-> (r_n <= (WIN_W+1)'(r_width)))
        else $error("window count exceeds window width");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.kind && i_item.last) |=> (r_state == S_CNT_RD))
        else $error("final acceptor beat did not start the comparison");
`endif

endmodule
